FILE: rtl/tlvp_pkg.sv
// Shared types, codes and helper functions for the TLV header field parser.
// Used by tlvp_parse_step, tlv_header_field_parser_core, tlvp_parse_checker and testbench; no dependencies.
package tlvp_pkg;

    // Position within the current element.
    typedef enum logic [1:0] {
        PH_TYPE   = 2'd0,
        PH_LEN_LO = 2'd1,
        PH_LEN_HI = 2'd2,
        PH_VALUE  = 2'd3
    } phase_t;

    // Result kinds.
    localparam logic [1:0] KIND_DATA  = 2'd0;
    localparam logic [1:0] KIND_FIELD = 2'd1;
    localparam logic [1:0] KIND_END   = 2'd2;
    localparam logic [1:0] KIND_TRUNC = 2'd3;

    // Element type whose value bytes pass straight out.
    localparam logic [7:0] DATA_TYPE = 8'd7;

    // Parser state carried from one beat to the next.
    typedef struct packed {
        phase_t      phase;
        logic [7:0]  elem_type;
        logic [7:0]  length_low;
        logic [14:0] bytes_left;
        logic [14:0] byte_pos;
        logic [31:0] accum;
    } parse_state_t;

    localparam parse_state_t PARSE_STATE_RESET = '{
        phase:      PH_TYPE,
        elem_type:  8'd0,
        length_low: 8'd0,
        bytes_left: 15'd0,
        byte_pos:   15'd0,
        accum:      32'd0
    };

    // One result beat plus a flag that says whether the input beat makes one.
    typedef struct packed {
        logic        emit;
        logic [1:0]  kind;
        logic [2:0]  field_id;
        logic [31:0] value;
        logic [14:0] data_offset;
        logic        end_flag;
    } parse_result_t;

    // Width in bytes of the field a type collects, zero if it is not a field.
    function automatic logic [2:0] field_width(input logic [7:0] elem_type);
        logic [2:0] w;
        begin
            unique case (elem_type)
                8'd1, 8'd2, 8'd5, 8'd6: w = 3'd2;
                8'd3, 8'd4:             w = 3'd4;
                default:                w = 3'd0;
            endcase
            return w;
        end
    endfunction

endpackage

FILE: rtl/tlv_header_field_parser_core.sv
// Top level of the TLV header field parser: parser state and result register.
// Depends on tlvp_pkg and tlvp_parse_step.

// Takes one datagram byte per beat and parses type-length-value elements
// (type byte, 16-bit little-endian length, value bytes). Each byte goes
// through one stage of logic into the result register, so the parser takes
// one byte per clock and a result, if the byte makes one, appears in the cycle
// after the byte is accepted. The input is stalled only while the result
// register holds a beat that the output side is not taking. Field types 1,
// 2, 5 and 6 give a 16-bit value and types 3 and 4 a 32-bit value when their
// element ends; type 7 value bytes come out one per beat with their offset.
// The last byte of a datagram always gives a result with end_flag set: a
// truncation report if an element was unfinished, otherwise the beat's own
// result or an end-only beat. The parser then restarts at a type byte.
module tlv_header_field_parser_core (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [7:0]  in_byte,
    input  logic        datagram_last,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [1:0]  kind,
    output logic [2:0]  field_id,
    output logic [31:0] value,
    output logic [14:0] data_offset,
    output logic        end_flag
);
    import tlvp_pkg::*;

    parse_state_t  state_reg;
    parse_state_t  state_next;
    parse_state_t  step_state;
    parse_result_t step_res;
    logic          out_valid_reg;
    logic          out_valid_next;
    logic [1:0]    kind_reg;
    logic [2:0]    field_id_reg;
    logic [31:0]   value_reg;
    logic [14:0]   data_offset_reg;
    logic          end_flag_reg;
    logic          in_fire;

    tlvp_parse_step u_step (
        .cur           (state_reg),
        .in_byte       (in_byte),
        .datagram_last (datagram_last),
        .nxt           (step_state),
        .res           (step_res)
    );

    // Accept a new beat whenever the result register is free or draining.
    assign in_ready = !out_valid_reg || out_ready;
    assign in_fire  = in_valid && in_ready;

    // State advances only on an accepted beat; the last byte restarts it.
    always_comb
    begin
        state_next = state_reg;
        if (in_fire)
        begin
            state_next = datagram_last ? PARSE_STATE_RESET : step_state;
        end
    end

    // Result valid follows the accepted beat or clears once taken.
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (in_fire)
        begin
            out_valid_next = step_res.emit;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= PARSE_STATE_RESET;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Result payload is loaded with each accepted beat that makes a result.
    always_ff @(posedge clk)
    begin
        if (in_fire && step_res.emit)
        begin
            kind_reg        <= step_res.kind;
            field_id_reg    <= step_res.field_id;
            value_reg       <= step_res.value;
            data_offset_reg <= step_res.data_offset;
            end_flag_reg    <= step_res.end_flag;
        end
    end

    assign out_valid   = out_valid_reg;
    assign kind        = kind_reg;
    assign field_id    = field_id_reg;
    assign value       = value_reg;
    assign data_offset = data_offset_reg;
    assign end_flag    = end_flag_reg;

endmodule

FILE: rtl/tlvp_parse_step.sv
// Combinational parse step: next parser state and the result of one byte.
// Depends on tlvp_pkg for the state and result types.
module tlvp_parse_step (
    input  tlvp_pkg::parse_state_t  cur,
    input  logic [7:0]              in_byte,
    input  logic                    datagram_last,
    output tlvp_pkg::parse_state_t  nxt,
    output tlvp_pkg::parse_result_t res
);
    import tlvp_pkg::*;

    logic        have;
    logic        data_now;
    logic [1:0]  kind_w;
    logic [2:0]  id_w;
    logic [31:0] val_w;
    logic [14:0] off_w;
    logic [15:0] len;
    logic [2:0]  cur_width;
    logic [2:0]  nxt_width;
    logic [2:0]  trunc_id;
    logic [14:0] left_dec;

    assign len       = {in_byte, cur.length_low};
    assign cur_width = field_width(cur.elem_type);
    assign left_dec  = cur.bytes_left - 15'd1;

    // Advance the element parser by one byte.
    always_comb
    begin
        nxt      = cur;
        have     = 1'b0;
        data_now = 1'b0;
        kind_w   = KIND_DATA;
        id_w     = 3'd0;
        val_w    = 32'd0;
        off_w    = 15'd0;
        unique case (cur.phase)
            PH_TYPE:
            begin
                nxt.elem_type = in_byte;
                nxt.phase     = PH_LEN_LO;
            end
            PH_LEN_LO:
            begin
                nxt.length_low = in_byte;
                nxt.phase      = PH_LEN_HI;
            end
            PH_LEN_HI:
            begin
                nxt.accum    = 32'd0;
                nxt.byte_pos = 15'd0;
                // A length with the top bit set counts as empty.
                if (len[15] || (len == 16'd0))
                begin
                    nxt.bytes_left = 15'd0;
                    nxt.phase      = PH_TYPE;
                    if (cur_width != 3'd0)
                    begin
                        have   = 1'b1;
                        kind_w = KIND_FIELD;
                        id_w   = cur.elem_type[2:0];
                    end
                end
                else
                begin
                    nxt.bytes_left = len[14:0];
                    nxt.phase      = PH_VALUE;
                end
            end
            PH_VALUE:
            begin
                if (cur_width != 3'd0)
                begin
                    // Little-endian collection; bytes past the width drop out.
                    if (cur.byte_pos < {12'd0, cur_width})
                    begin
                        nxt.accum = cur.accum
                                  | ({24'd0, in_byte} << {cur.byte_pos[1:0], 3'b000});
                    end
                end
                else if (cur.elem_type == DATA_TYPE)
                begin
                    have     = 1'b1;
                    data_now = 1'b1;
                    kind_w   = KIND_DATA;
                    val_w    = {24'd0, in_byte};
                    off_w    = cur.byte_pos;
                end
                nxt.byte_pos   = cur.byte_pos + 15'd1;
                nxt.bytes_left = left_dec;
                if (left_dec == 15'd0)
                begin
                    nxt.phase = PH_TYPE;
                    if (cur_width != 3'd0)
                    begin
                        have   = 1'b1;
                        kind_w = KIND_FIELD;
                        id_w   = cur.elem_type[2:0];
                        val_w  = nxt.accum;
                    end
                end
            end
            default:
            begin
                nxt = cur;
            end
        endcase
    end

    assign nxt_width = field_width(nxt.elem_type);
    assign trunc_id  = (nxt_width != 3'd0) ? nxt.elem_type[2:0] : 3'd0;

    // Final byte of a datagram: end marking and truncation report; the core resets the state.
    always_comb
    begin
        res.emit        = have;
        res.kind        = kind_w;
        res.field_id    = id_w;
        res.value       = val_w;
        res.data_offset = off_w;
        res.end_flag    = 1'b0;
        if (datagram_last)
        begin
            res.emit     = 1'b1;
            res.end_flag = 1'b1;
            if (nxt.phase != PH_TYPE)
            begin
                res.kind        = KIND_TRUNC;
                res.field_id    = trunc_id;
                res.value       = (trunc_id != 3'd0) ? nxt.accum :
                                  (data_now ? val_w : 32'd0);
                res.data_offset = (trunc_id == 3'd0 && data_now) ? off_w : 15'd0;
            end
            else if (!have)
            begin
                res.kind        = KIND_END;
                res.field_id    = 3'd0;
                res.value       = 32'd0;
                res.data_offset = 15'd0;
            end
        end
    end

endmodule

FILE: verif/tlvp_parse_checker.sv
// Result checker for the TLV header field parser: watches both channels,
// predicts each result from the accepted input bytes and compares field by field.
// Depends on tlvp_pkg for the phase encoding, result kinds and data type code.
module tlvp_parse_checker (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    input  logic        in_ready,
    input  logic [7:0]  in_byte,
    input  logic        datagram_last,
    input  logic        out_valid,
    input  logic        out_ready,
    input  logic [1:0]  kind,
    input  logic [2:0]  field_id,
    input  logic [31:0] value,
    input  logic [14:0] data_offset,
    input  logic        end_flag,
    output int          fail_count,
    output int          outstanding
);
    timeunit 1ns;
    timeprecision 1ps;

    import tlvp_pkg::*;

    // One predicted result beat.
    typedef struct packed {
        logic [1:0]  kind;
        logic [2:0]  field_id;
        logic [31:0] value;
        logic [14:0] data_offset;
        logic        end_flag;
    } field_report_t;

    field_report_t expected_reports[$];

    // Shadow copy of the parser state.
    phase_t      cur_phase;
    logic [7:0]  cur_type;
    logic [7:0]  len_low;
    logic [14:0] remaining;
    logic [14:0] position;
    logic [31:0] accum;

    // Number of value bytes a type collects into a field, zero for non-field types.
    function automatic logic [2:0] bytes_in_field(input logic [7:0] t);
        logic [2:0] n;
        begin
            case (t)
                8'd1, 8'd2, 8'd5, 8'd6: n = 3'd2;
                8'd3, 8'd4:             n = 3'd4;
                default:                n = 3'd0;
            endcase
            return n;
        end
    endfunction

    task automatic clear_parser();
        begin
            cur_phase = PH_TYPE;
            cur_type  = 8'd0;
            len_low   = 8'd0;
            remaining = 15'd0;
            position  = 15'd0;
            accum     = 32'd0;
        end
    endtask

    // Advance the shadow parser by one byte and queue the result it makes, if any.
    task automatic parse_byte(input logic [7:0] b, input logic last);
        logic          have;
        logic          data_now;
        logic [2:0]    size;
        logic [15:0]   len;
        field_report_t rep;
        begin
            have     = 1'b0;
            data_now = 1'b0;
            rep      = '0;
            case (cur_phase)
                PH_TYPE:
                begin
                    cur_type  = b;
                    cur_phase = PH_LEN_LO;
                end
                PH_LEN_LO:
                begin
                    len_low   = b;
                    cur_phase = PH_LEN_HI;
                end
                PH_LEN_HI:
                begin
                    len      = {b, len_low};
                    accum    = 32'd0;
                    position = 15'd0;
                    // Zero length or bit 15 set: the element is empty.
                    if (len[15] || len == 16'd0)
                    begin
                        remaining = 15'd0;
                        cur_phase = PH_TYPE;
                        if (bytes_in_field(cur_type) != 3'd0)
                        begin
                            have         = 1'b1;
                            rep.kind     = KIND_FIELD;
                            rep.field_id = cur_type[2:0];
                        end
                    end
                    else
                    begin
                        remaining = len[14:0];
                        cur_phase = PH_VALUE;
                    end
                end
                default:
                begin
                    size = bytes_in_field(cur_type);
                    // Little-endian collection; bytes past the field width are dropped.
                    if (size != 3'd0)
                    begin
                        if (position < 15'(size))
                            accum = accum | ({24'd0, b} << (8 * position[1:0]));
                    end
                    else if (cur_type == DATA_TYPE)
                    begin
                        have            = 1'b1;
                        data_now        = 1'b1;
                        rep.kind        = KIND_DATA;
                        rep.value       = {24'd0, b};
                        rep.data_offset = position;
                    end
                    position  = position + 15'd1;
                    remaining = remaining - 15'd1;
                    if (remaining == 15'd0)
                    begin
                        cur_phase = PH_TYPE;
                        if (size != 3'd0)
                        begin
                            have         = 1'b1;
                            rep.kind     = KIND_FIELD;
                            rep.field_id = cur_type[2:0];
                            rep.value    = accum;
                        end
                    end
                end
            endcase

            // The last byte of a datagram always reports, then the parser restarts.
            if (last)
            begin
                if (cur_phase != PH_TYPE)
                begin
                    // Unfinished element: a truncation report replaces any other result.
                    rep.kind     = KIND_TRUNC;
                    rep.field_id = 3'd0;
                    if (bytes_in_field(cur_type) != 3'd0)
                    begin
                        rep.field_id    = cur_type[2:0];
                        rep.value       = accum;
                        rep.data_offset = 15'd0;
                    end
                    else if (!data_now)
                    begin
                        rep.value       = 32'd0;
                        rep.data_offset = 15'd0;
                    end
                end
                else if (!have)
                begin
                    rep      = '0;
                    rep.kind = KIND_END;
                end
                rep.end_flag = 1'b1;
                expected_reports.push_back(rep);
                clear_parser();
            end
            else if (have)
            begin
                expected_reports.push_back(rep);
            end
        end
    endtask

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        begin
            if (want !== got)
            begin
                $display("%0t ns: %s mismatch, expected 0x%0h, actual 0x%0h",
                         $time, name, want, got);
                fail_count++;
            end
        end
    endtask

    // Predict on every accepted input beat and compare every accepted result beat.
    always @(posedge clk or negedge rst_n)
    begin
        field_report_t want;
        if (!rst_n)
        begin
            clear_parser();
            expected_reports.delete();
            outstanding <= 0;
        end
        else
        begin
            if (in_valid && in_ready)
                parse_byte(in_byte, datagram_last);

            if (out_valid && out_ready)
            begin
                if (expected_reports.size() == 0)
                begin
                    $display({"%0t ns: unexpected result, expected none, actual kind %0d",
                              " id %0d value 0x%0h offset %0d end %0b"},
                             $time, kind, field_id, value, data_offset, end_flag);
                    fail_count++;
                end
                else
                begin
                    want = expected_reports.pop_front();
                    check_field("kind", 32'(want.kind), 32'(kind));
                    check_field("field_id", 32'(want.field_id), 32'(field_id));
                    check_field("value", want.value, value);
                    check_field("data_offset", 32'(want.data_offset), 32'(data_offset));
                    check_field("end_flag", 32'(want.end_flag), 32'(end_flag));
                end
            end
            outstanding <= expected_reports.size();
        end
    end

endmodule

FILE: verif/testbench.sv
// Top of the TLV header field parser testbench: clock, reset, byte stimulus,
// output back-pressure and the final verdict. Depends on tlvp_pkg,
// tlv_header_field_parser_core and tlvp_parse_checker.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import tlvp_pkg::*;

    localparam int         TARGET_BEATS  = 1200;
    localparam int         HOLD_CYCLES   = 60;
    localparam logic [7:0] UNKNOWN_TYPE  = 8'd0;
    localparam logic [7:0] FIELD32_TYPE  = 8'd4;
    localparam logic [7:0] FIELD16_TYPE  = 8'd5;

    logic        clk           = 1'b0;
    logic        rst_n         = 1'b0;
    logic        in_valid      = 1'b0;
    logic [7:0]  in_byte       = 8'd0;
    logic        datagram_last = 1'b0;
    logic        out_ready     = 1'b0;
    logic        in_ready;
    logic        out_valid;
    logic [1:0]  kind;
    logic [2:0]  field_id;
    logic [31:0] value;
    logic [14:0] data_offset;
    logic        end_flag;

    int          fail_count;
    int          outstanding;
    int          beats_sent    = 0;
    logic        quiet_stretch = 1'b0;
    logic [3:0]  hold_req      = 4'd0;
    logic [3:0]  hold_seen     = 4'd0;
    int          hold_left     = 0;
    logic [7:0]  dgram[$];

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    tlv_header_field_parser_core dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .in_byte       (in_byte),
        .datagram_last (datagram_last),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .kind          (kind),
        .field_id      (field_id),
        .value         (value),
        .data_offset   (data_offset),
        .end_flag      (end_flag)
    );

    tlvp_parse_checker result_check (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .in_byte       (in_byte),
        .datagram_last (datagram_last),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .kind          (kind),
        .field_id      (field_id),
        .value         (value),
        .data_offset   (data_offset),
        .end_flag      (end_flag),
        .fail_count    (fail_count),
        .outstanding   (outstanding)
    );

    // Result side: random stalls, plus a long hold-off whenever one is requested.
    always @(posedge clk)
    begin
        if (hold_left != 0)
        begin
            out_ready <= 1'b0;
            hold_left <= hold_left - 1;
        end
        else if (hold_req != hold_seen)
        begin
            hold_seen <= hold_req;
            hold_left <= HOLD_CYCLES;
            out_ready <= 1'b0;
        end
        else
        begin
            out_ready <= rst_n && (quiet_stretch || $urandom_range(99) >= 14);
        end
    end

    // Offer one byte beat and return at the edge that accepts it.
    task automatic send_beat(input logic [7:0] b, input logic last);
        begin
            if (!quiet_stretch && $urandom_range(99) < 14)
            begin
                in_valid <= 1'b0;
                repeat ($urandom_range(1, 3)) @(posedge clk);
            end
            in_valid      <= 1'b1;
            in_byte       <= b;
            datagram_last <= last;
            @(posedge clk);
            while (!in_ready) @(posedge clk);
            beats_sent++;
        end
    endtask

    task automatic send_datagram();
        begin
            foreach (dgram[i])
                send_beat(dgram[i], i == dgram.size() - 1);
        end
    endtask

    // Append one element: type, little-endian length and a number of random value bytes.
    task automatic add_element(input logic [7:0] t, input logic [15:0] len, input int nvals);
        begin
            dgram.push_back(t);
            dgram.push_back(len[7:0]);
            dgram.push_back(len[15:8]);
            repeat (nvals) dgram.push_back(8'($urandom));
        end
    endtask

    task automatic add_random_element();
        int          pick;
        logic [7:0]  t;
        logic [15:0] len;
        begin
            pick = $urandom_range(99);
            if (pick < 55)
                t = 8'($urandom_range(1, 6));
            else if (pick < 75)
                t = DATA_TYPE;
            else if (pick < 88)
                t = ($urandom_range(1) == 0) ? UNKNOWN_TYPE : 8'($urandom_range(8, 255));
            else
                t = 8'($urandom_range(255));
            pick = $urandom_range(99);
            if (pick < 70)
                len = 16'($urandom_range(0, 6));
            else if (pick < 85)
                len = 16'($urandom_range(7, 24));
            else
                len = {1'b1, 15'($urandom)};
            add_element(t, len, len[15] ? 0 : int'(len));
        end
    endtask

    // Mostly well-formed datagrams; some end in a broken element, a few are raw noise.
    task automatic build_random_datagram();
        int pick;
        begin
            dgram.delete();
            pick = $urandom_range(99);
            if (pick < 10)
            begin
                repeat ($urandom_range(1, 12)) dgram.push_back(8'($urandom));
            end
            else
            begin
                repeat ($urandom_range(1, 4)) add_random_element();
                if (pick >= 85)
                begin
                    add_element(8'($urandom), 16'($urandom), $urandom_range(0, 6));
                    repeat ($urandom_range(0, 2))
                        if (dgram.size() > 1)
                            void'(dgram.pop_back());
                end
            end
        end
    endtask

    // Stop offering and wait until every predicted result has been taken.
    task automatic drain_results();
        begin
            in_valid <= 1'b0;
            @(posedge clk);
            while (outstanding != 0) @(posedge clk);
        end
    endtask

    // Main stimulus.
    initial
    begin
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // 32-bit field with an extra byte, then a 16-bit field missing its high byte.
        dgram = {FIELD32_TYPE, 8'h05, 8'h00, 8'hFF, 8'h00, 8'h80, 8'hFF, 8'h55,
                 FIELD16_TYPE, 8'h01, 8'h00, 8'h5A};
        send_datagram();
        // Data byte, empty field by length bit 15, empty unknown element: end only.
        dgram = {DATA_TYPE, 8'h01, 8'h00, 8'hAB, FIELD16_TYPE, 8'h00, 8'h80,
                 UNKNOWN_TYPE, 8'h00, 8'h00};
        send_datagram();
        // Truncated field, truncated data element, and a datagram of a type byte alone.
        dgram = {FIELD32_TYPE, 8'h04, 8'h00, 8'h12};
        send_datagram();
        dgram = {DATA_TYPE, 8'h02, 8'h00, 8'h01};
        send_datagram();
        dgram = {8'hFF};
        send_datagram();

        // Long data element and a 32-bit field while the result side holds off, then a full pause.
        hold_req <= hold_req + 4'd1;
        dgram.delete();
        add_element(DATA_TYPE, 16'd40, 40);
        add_element(FIELD32_TYPE, 16'd4, 4);
        send_datagram();
        drain_results();
        repeat (3) @(posedge clk);

        // Random datagrams, with a stretch free of idling and a second hold-off.
        while (beats_sent < TARGET_BEATS)
        begin
            quiet_stretch <= (beats_sent >= 500 && beats_sent < 800);
            if (beats_sent >= 950 && hold_req == 4'd1)
                hold_req <= hold_req + 4'd1;
            build_random_datagram();
            send_datagram();
        end
        quiet_stretch <= 1'b0;

        drain_results();
        repeat (10) @(posedge clk);
        if (fail_count == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

    // Hang guard.
    initial
    begin
        #500_000;
        $display("Regression FAIL");
        $finish;
    end

endmodule
